// File: src/assert_macros.svh
// assertion macros used by the axis rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property over time, checked on the rising clock, off during reset
`define ASSERT_SEQ(lbl, clk_i, rstn_i, prop) \
lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (prop)) \
	else $error("temporal check failed");

// condition that must never be true at a clock edge
`define ASSERT_NEVER(lbl, clk_i, rstn_i, cond) \
lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) !(cond)) \
	else $error("forbidden condition seen");

`endif

// File: src/tpm_pkg.sv
// shared types and constants of the tilt to pointer motion block
`timescale 1ns / 1ps

package tpm_pkg;

	localparam int SAMPLE_W = 16;
	localparam int LEVEL_W  = 15;
	localparam int SPEED_W  = 5;
	localparam int TICK_W   = 8;
	localparam int STEP_W   = 8;
	localparam int GAIN_W   = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 15;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_DEADZONE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SMALL_TILT  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_LARGE_TILT  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SLOW_SPEED  = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_FAST_SPEED  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_TWO   = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THREE = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LEVEL_FOUR  = 3'd7;

	// reset values of the registers
	localparam logic [LEVEL_W-1:0] DEADZONE_RST    = 15'd800;
	localparam logic [LEVEL_W-1:0] SMALL_TILT_RST  = 15'd3000;
	localparam logic [LEVEL_W-1:0] LARGE_TILT_RST  = 15'd8000;
	localparam logic [SPEED_W-1:0] SLOW_SPEED_RST  = 5'd3;
	localparam logic [SPEED_W-1:0] FAST_SPEED_RST  = 5'd8;
	localparam logic [TICK_W-1:0]  LEVEL_TWO_RST   = 8'd5;
	localparam logic [TICK_W-1:0]  LEVEL_THREE_RST = 8'd15;
	localparam logic [TICK_W-1:0]  LEVEL_FOUR_RST  = 8'd30;

	// gain codes
	localparam logic [GAIN_W-1:0] GAIN_ONE   = 3'd1;
	localparam logic [GAIN_W-1:0] GAIN_TWO   = 3'd2;
	localparam logic [GAIN_W-1:0] GAIN_FOUR  = 3'd4;
	localparam logic [GAIN_W-1:0] GAIN_SIX   = 3'd6;

	localparam logic [TICK_W-1:0] TICK_MAX = '1;
	localparam logic [STEP_W-1:0] STEP_MAX = 8'd127;

	typedef struct packed {
		logic [LEVEL_W-1:0] deadzone;
		logic [LEVEL_W-1:0] small_tilt;
		logic [LEVEL_W-1:0] large_tilt;
		logic [SPEED_W-1:0] slow_speed;
		logic [SPEED_W-1:0] fast_speed;
		logic [TICK_W-1:0]  level_two;
		logic [TICK_W-1:0]  level_three;
		logic [TICK_W-1:0]  level_four;
	} cfg_t;

endpackage

// File: src/tpm_axis.sv
// one axis: deadzone, band sort, tilt tick counter, gain and saturated step
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tpm_axis import tpm_pkg::*; (
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       flip,
	input  logic                       upd,
	input  logic signed [SAMPLE_W-1:0] sample,
	output logic signed [STEP_W-1:0]   step,
	output logic        [GAIN_W-1:0]   gain
);

	logic [TICK_W-1:0] cnt_q;
	logic [TICK_W-1:0] cnt_next;
	logic signed [SAMPLE_W:0] vs, dz_s, sm_s, lg_s;
	logic dead, tilted, neg;
	logic [SPEED_W-1:0] speed;
	logic [STEP_W-1:0] prod, mag;

	assign vs   = {sample[SAMPLE_W-1], sample};
	assign dz_s = $signed({2'b00, cfg.deadzone});
	assign sm_s = $signed({2'b00, cfg.small_tilt});
	assign lg_s = $signed({2'b00, cfg.large_tilt});

	// inside the deadzone the sample reads as zero, which sits in no band
	assign dead = (vs > -dz_s) && (vs < dz_s);

	always_comb begin
		tilted = 1'b1;
		neg    = 1'b0;
		speed  = '0;
		priority if (dead) begin
			tilted = 1'b0;
		end else if (vs < -lg_s) begin
			neg   = 1'b1;
			speed = cfg.fast_speed;
		end else if (vs < -sm_s) begin
			neg   = 1'b1;
			speed = cfg.slow_speed;
		end else if (vs > lg_s) begin
			speed = cfg.fast_speed;
		end else if (vs > sm_s) begin
			speed = cfg.slow_speed;
		end else begin
			tilted = 1'b0;
		end
	end

	always_comb begin
		if (!tilted)
			cnt_next = '0;
		else if (cnt_q == TICK_MAX)
			cnt_next = TICK_MAX;
		else
			cnt_next = cnt_q + 1'b1;
	end

	always_comb begin
		priority if (!tilted)
			gain = GAIN_ONE;
		else if (cnt_next < cfg.level_two)
			gain = GAIN_ONE;
		else if (cnt_next < cfg.level_three)
			gain = GAIN_TWO;
		else if (cnt_next < cfg.level_four)
			gain = GAIN_FOUR;
		else
			gain = GAIN_SIX;
	end

	assign prod = STEP_W'(speed) * STEP_W'(gain);
	assign mag  = (prod > STEP_MAX) ? STEP_MAX : prod;
	assign step = (neg ^ flip) ? -$signed(mag) : $signed(mag);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (upd) begin
			cnt_q <= cnt_next;
		end
	end

	`ASSERT_SEQ(a_cnt_clear, clk, arst_n, upd && !tilted |=> cnt_q == '0)
	`ASSERT_SEQ(a_cnt_sat, clk, arst_n, upd && tilted && cnt_q == TICK_MAX |=> cnt_q == TICK_MAX)
	`ASSERT_SEQ(a_cnt_hold, clk, arst_n, !upd |=> cnt_q == $past(cnt_q))
	`ASSERT_NEVER(a_idle_step, clk, arst_n, upd && !tilted && step != '0)

endmodule

// File: src/tilt_to_pointer_motion_core.sv
// top level: configuration registers, input stage, two axes and result register
`timescale 1ns / 1ps
//
// Turns one X/Y tilt sample pair per transfer into a pointer step.
// Input channel: tilt_x, tilt_y with in_valid / in_stall; a transfer happens
// at a rising edge with in_valid high and in_stall low.
// Output channel: move_x, move_y, gain_x, gain_y, moved with out_valid /
// out_stall, same rule.
// A sample taken at an edge is registered in the input stage, worked out by the
// axes and written to the result register when stage one advances.
// Throughput: one sample pair per cycle while out_stall is low; the per-axis
// tick counters update as stage one advances, so samples follow with no gap.
// A stall on the output holds the result register; the input stage keeps
// taking one more sample, then in_stall rises until the result is taken.
// Configuration: cfg_we with cfg_index and cfg_wdata writes one register at
// an edge; write only while no sample is in flight.
// Reset: arst_n clears both stages, the tick counters and loads the default
// register values; the block takes samples from the first edge after reset.
//
module tilt_to_pointer_motion_core import tpm_pkg::*; (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [CFG_IDX_W-1:0]        cfg_index,
	input  logic [CFG_DATA_W-1:0]       cfg_wdata,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic signed [SAMPLE_W-1:0]  tilt_x,
	input  logic signed [SAMPLE_W-1:0]  tilt_y,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic signed [STEP_W-1:0]    move_x,
	output logic signed [STEP_W-1:0]    move_y,
	output logic [GAIN_W-1:0]           gain_x,
	output logic [GAIN_W-1:0]           gain_y,
	output logic                        moved
);

	cfg_t cfg_q;
	logic valid_s1;
	logic signed [SAMPLE_W-1:0] tilt_x_s1, tilt_y_s1;
	logic out_valid_q;
	logic signed [STEP_W-1:0] move_x_q, move_y_q;
	logic [GAIN_W-1:0] gain_x_q, gain_y_q;
	logic moved_q;
	logic adv;
	logic signed [STEP_W-1:0] step_x, step_y;
	logic [GAIN_W-1:0] gx, gy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.deadzone    <= DEADZONE_RST;
			cfg_q.small_tilt  <= SMALL_TILT_RST;
			cfg_q.large_tilt  <= LARGE_TILT_RST;
			cfg_q.slow_speed  <= SLOW_SPEED_RST;
			cfg_q.fast_speed  <= FAST_SPEED_RST;
			cfg_q.level_two   <= LEVEL_TWO_RST;
			cfg_q.level_three <= LEVEL_THREE_RST;
			cfg_q.level_four  <= LEVEL_FOUR_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEADZONE:    cfg_q.deadzone    <= cfg_wdata;
				REG_SMALL_TILT:  cfg_q.small_tilt  <= cfg_wdata;
				REG_LARGE_TILT:  cfg_q.large_tilt  <= cfg_wdata;
				REG_SLOW_SPEED:  cfg_q.slow_speed  <= cfg_wdata[SPEED_W-1:0];
				REG_FAST_SPEED:  cfg_q.fast_speed  <= cfg_wdata[SPEED_W-1:0];
				REG_LEVEL_TWO:   cfg_q.level_two   <= cfg_wdata[TICK_W-1:0];
				REG_LEVEL_THREE: cfg_q.level_three <= cfg_wdata[TICK_W-1:0];
				REG_LEVEL_FOUR:  cfg_q.level_four  <= cfg_wdata[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	// stage one moves on whenever the result register is free or being drained
	assign adv      = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && out_valid_q && out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && !in_stall) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			tilt_x_s1 <= tilt_x;
			tilt_y_s1 <= tilt_y;
		end
	end

	tpm_axis u_axis_x (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.flip   (1'b0),
		.upd    (adv),
		.sample (tilt_x_s1),
		.step   (step_x),
		.gain   (gx)
	);

	// y steps run opposite to the y tilt
	tpm_axis u_axis_y (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.flip   (1'b1),
		.upd    (adv),
		.sample (tilt_y_s1),
		.step   (step_y),
		.gain   (gy)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			move_x_q <= step_x;
			move_y_q <= step_y;
			gain_x_q <= gx;
			gain_y_q <= gy;
			moved_q  <= (step_x != '0) || (step_y != '0);
		end
	end

	assign out_valid = out_valid_q;
	assign move_x    = move_x_q;
	assign move_y    = move_y_q;
	assign gain_x    = gain_x_q;
	assign gain_y    = gain_y_q;
	assign moved     = moved_q;

endmodule
